/* src/tsq_pkg.sv */
// Package for the two-stack queue: sizes, status codes and stack control type.
// No dependencies; used by every module in src.
package tsq_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] ST_ENQ_OK    = 2'd0;
    localparam logic [1:0] ST_ENQ_FULL  = 2'd1;
    localparam logic [1:0] ST_DEQ_OK    = 2'd2;
    localparam logic [1:0] ST_DEQ_EMPTY = 2'd3;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    typedef struct packed {
        logic push;
        logic pop;
    } stack_ctrl_t;

endpackage

/* src/tsq_cell.sv */
// One storage cell of a stack chain: takes the word above on push, below on pop.
// Depends on tsq_pkg.
module tsq_cell (
    input  logic                          clk,
    input  tsq_pkg::stack_ctrl_t          ctrl,
    input  logic [tsq_pkg::DATA_WIDTH-1:0] up_data,
    input  logic [tsq_pkg::DATA_WIDTH-1:0] down_data,
    output logic [tsq_pkg::DATA_WIDTH-1:0] data
);

    logic [tsq_pkg::DATA_WIDTH-1:0] data_reg;
    logic [tsq_pkg::DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        priority if (ctrl.push)
        begin
            data_next = up_data;
        end
        else if (ctrl.pop)
        begin
            data_next = down_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* src/tsq_stack.sv */
// Bounded stack as a row of shifting cells, top at cell 0, plus its fill count.
// Depends on tsq_pkg and tsq_cell.
module tsq_stack (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tsq_pkg::stack_ctrl_t           ctrl,
    input  logic [tsq_pkg::DATA_WIDTH-1:0] push_data,
    output logic [tsq_pkg::DATA_WIDTH-1:0] top_data,
    output logic [tsq_pkg::CNT_W-1:0]      count
);

    logic [tsq_pkg::DATA_WIDTH-1:0] cell_data [tsq_pkg::STACK_DEPTH];
    logic [tsq_pkg::CNT_W-1:0]      count_reg;
    logic [tsq_pkg::CNT_W-1:0]      count_next;

    for (genvar i = 0; i < tsq_pkg::STACK_DEPTH; i++)
    begin : g_cell
        logic [tsq_pkg::DATA_WIDTH-1:0] up_data;
        logic [tsq_pkg::DATA_WIDTH-1:0] down_data;

        if (i == 0)
        begin : g_top
            assign up_data = push_data;
        end
        else
        begin : g_mid_up
            assign up_data = cell_data[i-1];
        end

        if (i == tsq_pkg::STACK_DEPTH - 1)
        begin : g_bottom
            assign down_data = cell_data[i];
        end
        else
        begin : g_mid_down
            assign down_data = cell_data[i+1];
        end

        tsq_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .up_data   (up_data),
            .down_data (down_data),
            .data      (cell_data[i])
        );
    end

    always_comb
    begin
        priority if (ctrl.push)
        begin
            count_next = count_reg + tsq_pkg::CNT_W'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - tsq_pkg::CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign top_data = cell_data[0];
    assign count    = count_reg;

endmodule

/* src/two_stack_queue_top.sv */
// Top level of the two-stack queue: control sequencer, two cell-chain stacks, output register.
// Depends on tsq_pkg and tsq_stack.
//
//  channel | dir | tdata          | tuser
//  s_axis  | in  | value[31:0]    | action[0]
//  m_axis  | out | out_value[31:0]| status[1:0]
//
// Enqueue and dequeue from a non-empty output stack are taken back to back while m_axis is not stalled.
// Dequeue onto an empty output stack walks the input stack across, one word a
// cycle through the cell chains, then pops the result once m_axis has room.
// s_axis_tready is low during that walk and while a result waits on a stalled m_axis.
// rst_n clears the counts, sequencer and output valid; cell contents are not reset.
module two_stack_queue_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [0:0]  s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] out_value
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    typedef enum logic {
        ST_RUN,
        ST_REFILL
    } state_t;

    state_t state_reg;
    state_t state_next;

    tsq_pkg::stack_ctrl_t in_ctrl;
    tsq_pkg::stack_ctrl_t out_ctrl;

    logic [tsq_pkg::DATA_WIDTH-1:0] in_top;
    logic [tsq_pkg::DATA_WIDTH-1:0] out_top;
    logic [tsq_pkg::CNT_W-1:0]      in_count;
    logic [tsq_pkg::CNT_W-1:0]      out_count;

    logic in_full;
    logic in_empty;
    logic out_empty;
    logic slot_free;
    logic accept;
    logic load;

    logic                           m_valid_reg;
    logic                           m_valid_next;
    logic [1:0]                     status_reg;
    logic [1:0]                     status_next;
    logic [tsq_pkg::DATA_WIDTH-1:0] value_reg;
    logic [tsq_pkg::DATA_WIDTH-1:0] value_next;

    assign in_full   = (in_count == tsq_pkg::CNT_W'(tsq_pkg::STACK_DEPTH));
    assign in_empty  = (in_count == '0);
    assign out_empty = (out_count == '0);
    assign slot_free = !m_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == ST_RUN) && slot_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    tsq_stack u_in_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (in_ctrl),
        .push_data (s_axis_tdata),
        .top_data  (in_top),
        .count     (in_count)
    );

    tsq_stack u_out_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (out_ctrl),
        .push_data (in_top),
        .top_data  (out_top),
        .count     (out_count)
    );

    always_comb
    begin
        in_ctrl     = '0;
        out_ctrl    = '0;
        state_next  = state_reg;
        load        = 1'b0;
        status_next = status_reg;
        value_next  = value_reg;

        unique case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    if (s_axis_tuser[0] == tsq_pkg::ACT_ENQ)
                    begin
                        load       = 1'b1;
                        value_next = '0;
                        if (in_full)
                        begin
                            status_next = tsq_pkg::ST_ENQ_FULL;
                        end
                        else
                        begin
                            in_ctrl.push = 1'b1;
                            status_next  = tsq_pkg::ST_ENQ_OK;
                        end
                    end
                    else if (!out_empty)
                    begin
                        out_ctrl.pop = 1'b1;
                        load         = 1'b1;
                        status_next  = tsq_pkg::ST_DEQ_OK;
                        value_next   = out_top;
                    end
                    else if (in_empty)
                    begin
                        load        = 1'b1;
                        status_next = tsq_pkg::ST_DEQ_EMPTY;
                        value_next  = '0;
                    end
                    else
                    begin
                        state_next = ST_REFILL;
                    end
                end
            end
            ST_REFILL:
            begin
                if (!in_empty)
                begin
                    in_ctrl.pop   = 1'b1;
                    out_ctrl.push = 1'b1;
                end
                else if (slot_free)
                begin
                    out_ctrl.pop = 1'b1;
                    load         = 1'b1;
                    status_next  = tsq_pkg::ST_DEQ_OK;
                    value_next   = out_top;
                    state_next   = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        m_valid_next = load || (m_valid_reg && !m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_RUN;
            m_valid_reg <= 1'b0;
            status_reg  <= tsq_pkg::ST_ENQ_OK;
            value_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            status_reg  <= status_next;
            value_reg   <= value_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = value_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (in_count <= tsq_pkg::CNT_W'(tsq_pkg::STACK_DEPTH))
        && (out_count <= tsq_pkg::CNT_W'(tsq_pkg::STACK_DEPTH)))
        else $error("stack count beyond depth");

    a_refill_move: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REFILL && !in_empty)
        |=> (out_count == $past(out_count) + tsq_pkg::CNT_W'(1))
            && (in_count == $past(in_count) - tsq_pkg::CNT_W'(1)))
        else $error("refill walk did not move one word");

    a_refill_from_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && state_next == ST_REFILL) |-> (out_empty && !in_empty))
        else $error("refill started with output stack occupied");

    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != tsq_pkg::ST_DEQ_OK) |-> (m_axis_tdata == '0))
        else $error("non-dequeue result carries data");

endmodule
